// File: hdl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and constants for the polygon point-inclusion block.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int COUNT_BITS    = 6;
  localparam int IDX_BITS      = 5;
  localparam int IN_COORD_BITS = 16;

  localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RESET = 6'd3;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  typedef struct packed {
    logic [1:0]                       command;
    logic [IDX_BITS-1:0]              vertex_index;
    logic signed [IN_COORD_BITS-1:0]  coord_x;
    logic signed [IN_COORD_BITS-1:0]  coord_y;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic rejected;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic write;
    logic move_rd;
    logic move_wr;
    logic walk_start;
    logic walk_rd;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reject;
    logic count_zero;
    logic walk_last;
    logic busy;
    logic parity;
  } dp_status_t;

endpackage

// File: hdl/ppi_datapath.sv
// ----------------------------------------------------------------------------
// ppi_datapath
// Vertex memory, write/move saturation, and the edge-crossing pipeline.
// ----------------------------------------------------------------------------
module ppi_datapath #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ppi_pkg::in_item_t                 in_item,
  input  logic [ppi_pkg::COUNT_BITS-1:0]    vertex_count,
  input  ppi_pkg::dp_cmd_t                  cmd,
  output ppi_pkg::dp_status_t               status
);
  import ppi_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (NW > COUNT_BITS) ? NW : COUNT_BITS;
  localparam int PW = (COORD_BITS > IN_COORD_BITS) ? COORD_BITS : IN_COORD_BITS;
  localparam int DW = PW + 1;
  localparam int MW = 2 * DW;
  localparam logic signed [DW-1:0] SAT_HI = DW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [DW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [COORD_BITS-1:0] sat(input logic signed [DW-1:0] v);
    logic [COORD_BITS-1:0] r;
    priority if (v > SAT_HI) begin
      r = SAT_HI[COORD_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // captured item
  logic [IDX_BITS-1:0]             item_idx;
  logic signed [IN_COORD_BITS-1:0] item_x;
  logic signed [IN_COORD_BITS-1:0] item_y;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_idx <= in_item.vertex_index;
      item_x   <= in_item.coord_x;
      item_y   <= in_item.coord_y;
    end
  end

  logic [CW-1:0] count_ext;
  logic [CW-1:0] eff_count;

  assign count_ext = CW'(vertex_count);
  assign eff_count = (count_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : count_ext;

  // vertex memory: x in the upper half, y in the lower half
  logic [2*COORD_BITS-1:0] vmem [MAX_VERTICES];
  logic [2*COORD_BITS-1:0] rdata;
  logic [CW-1:0]           walk_i;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic                    rd_en;
  logic                    wr_en;
  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;
  logic signed [DW-1:0]    sum_x;
  logic signed [DW-1:0]    sum_y;
  logic [2*COORD_BITS-1:0] wr_data;

  assign rd_en   = cmd.move_rd | cmd.walk_rd;
  assign wr_en   = cmd.write | cmd.move_wr;
  assign rd_addr = cmd.walk_rd ? walk_i[AW-1:0] : AW'(item_idx);
  assign wr_addr = AW'(item_idx);
  assign rd_x    = signed'(rdata[2*COORD_BITS-1:COORD_BITS]);
  assign rd_y    = signed'(rdata[COORD_BITS-1:0]);

  // a write adds the coordinate to zero, a move adds the offset to the stored vertex
  assign sum_x   = (cmd.move_wr ? DW'(rd_x) : DW'(0)) + DW'(item_x);
  assign sum_y   = (cmd.move_wr ? DW'(rd_y) : DW'(0)) + DW'(item_y);
  assign wr_data = {sat(sum_x), sat(sum_y)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= vmem[rd_addr];
    end
  end

  // walk counter and read tags
  logic walk_last;
  logic tag_vld;
  logic tag_first;
  logic tag_last;
  logic close_pend;

  assign walk_last = (walk_i == eff_count - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_i     <= '0;
      tag_vld    <= 1'b0;
      tag_first  <= 1'b0;
      tag_last   <= 1'b0;
      close_pend <= 1'b0;
    end else begin
      if (cmd.walk_start) begin
        walk_i <= '0;
      end else if (cmd.walk_rd) begin
        walk_i <= walk_i + CW'(1);
      end
      tag_vld    <= cmd.walk_rd;
      tag_first  <= (walk_i == '0);
      tag_last   <= walk_last;
      close_pend <= tag_vld & tag_last;
    end
  end

  // edge assembly: each read vertex closes the edge from the previous one,
  // and the last vertex is followed by the wraparound edge back to vertex 0
  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [COORD_BITS-1:0] e_x1, e_y1, e_x2, e_y2;
  logic                         e_vld;

  always_ff @(posedge clk) begin
    if (tag_vld) begin
      if (tag_first) begin
        first_x <= rd_x;
        first_y <= rd_y;
      end
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
    e_x1 <= prev_x;
    e_y1 <= prev_y;
    e_x2 <= close_pend ? first_x : rd_x;
    e_y2 <= close_pend ? first_y : rd_y;
  end

  // stage 2: differences and y-range check
  logic signed [DW-1:0] py_e, y1_e, y2_e, dy_c;
  logic signed [DW-1:0] s2_dx, s2_dy, s2_qx, s2_qy;
  logic                 in_range;
  logic                 s2_vld;

  assign py_e     = DW'(item_y);
  assign y1_e     = DW'(e_y1);
  assign y2_e     = DW'(e_y2);
  assign dy_c     = y2_e - y1_e;
  assign in_range = ((py_e >= y1_e) && (py_e <= y2_e)) || ((py_e >= y2_e) && (py_e <= y1_e));

  always_ff @(posedge clk) begin
    s2_dx <= DW'(e_x2) - DW'(e_x1);
    s2_dy <= dy_c;
    s2_qx <= DW'(item_x) - DW'(e_x1);
    s2_qy <= py_e - y1_e;
  end

  // stage 3: cross products
  logic signed [MW-1:0] prod_a, prod_b, s3_pa, s3_pb;
  logic                 s3_pos, s3_neg;
  logic                 parity;

  assign prod_a = s2_qy * s2_dx;
  assign prod_b = s2_qx * s2_dy;

  always_ff @(posedge clk) begin
    s3_pa <= prod_a;
    s3_pb <= prod_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld  <= 1'b0;
      s2_vld <= 1'b0;
      s3_pos <= 1'b0;
      s3_neg <= 1'b0;
      parity <= 1'b0;
    end else begin
      e_vld  <= (tag_vld & ~tag_first) | close_pend;
      s2_vld <= e_vld & (dy_c != '0) & in_range;
      s3_pos <= s2_vld & ~s2_dy[DW-1];
      s3_neg <= s2_vld & s2_dy[DW-1];
      // stage 4: crossing x lies right of the point when the products order
      // matches the sign of dy
      if (cmd.walk_start) begin
        parity <= 1'b0;
      end else if ((s3_pos && (s3_pa > s3_pb)) || (s3_neg && (s3_pa < s3_pb))) begin
        parity <= ~parity;
      end
    end
  end

  assign status.reject     = (CW'(item_idx) >= eff_count);
  assign status.count_zero = (eff_count == '0);
  assign status.walk_last  = walk_last;
  assign status.busy       = tag_vld | close_pend | e_vld | s2_vld | s3_pos | s3_neg;
  assign status.parity     = parity;

endmodule

// File: hdl/ppi_ctrl.sv
// ----------------------------------------------------------------------------
// ppi_ctrl
// Command sequencer and result register for the point-inclusion block.
// ----------------------------------------------------------------------------
module ppi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ppi_pkg::out_item_t   out_item,
  output ppi_pkg::dp_cmd_t     cmd,
  input  ppi_pkg::dp_status_t  status
);
  import ppi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t     state;
  logic [1:0] op;
  out_item_t  res;
  logic       accept;
  logic       res_send;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  // the output register is free when empty or when its beat leaves this cycle
  assign res_send = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    cmd      = '0;
    cmd.load = accept;
    unique case (state)
      S_DECODE: begin
        unique case (op)
          CMD_WRITE: cmd.write      = ~status.reject;
          CMD_MOVE:  cmd.move_rd    = ~status.reject;
          CMD_TEST:  cmd.walk_start = 1'b1;
          default: ;
        endcase
      end
      S_MOVE:  cmd.move_wr = 1'b1;
      S_WALK:  cmd.walk_rd = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_send) begin
        out_valid <= 1'b1;
        out_item  <= res;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= in_command;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res.inside_res <= 1'b0;
          res.rejected   <= ((op == CMD_WRITE) || (op == CMD_MOVE)) & status.reject;
          unique case (op)
            CMD_WRITE: begin
              state <= S_FINISH;
            end
            CMD_MOVE: begin
              state <= status.reject ? S_FINISH : S_MOVE;
            end
            CMD_TEST: begin
              state <= status.count_zero ? S_FINISH : S_WALK;
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end
        S_MOVE: begin
          state <= S_FINISH;
        end
        S_WALK: begin
          if (status.walk_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait for the last edge to leave the pipeline
          if (!status.busy) begin
            res.inside_res <= status.parity;
            res.rejected   <= 1'b0;
            state          <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (res_send) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/polygon_point_inclusion.sv
// ----------------------------------------------------------------------------
// polygon_point_inclusion
// Polygon vertex store with write, saturating move and ray-casting point test.
// ----------------------------------------------------------------------------
//   channel   signals                          beat
//   in        in_valid / in_ready / in_item    command, index, x, y
//   out       out_valid / out_ready / out_item one result per input beat
//   cfg       cfg_wr_en / cfg_wr_data          vertex_count, no handshake
//
// Write, reject, unused commands and a test with no vertices go from
// accept through decode to the result; a move adds a vertex read and a
// write. A point test walks the n vertices in use through the single vertex
// memory read port, one vertex per cycle, then the four-stage crossing
// pipeline drains, sooner when the last edges are skipped. Synchronous
// reset clears control state and sets vertex_count to 3; the vertex memory
// is not cleared. A finished result waits in the output register while the
// next beat is taken; the next result holds until that register is free.
// ----------------------------------------------------------------------------
module polygon_point_inclusion #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ppi_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ppi_pkg::out_item_t              out_item,
  input  logic                            cfg_wr_en,
  input  logic [ppi_pkg::COUNT_BITS-1:0]  cfg_wr_data
);
  import ppi_pkg::*;

  logic [COUNT_BITS-1:0] vertex_count;
  dp_cmd_t               cmd;
  dp_status_t            status;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  ppi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_item.command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cmd        (cmd),
    .status     (status)
  );

  ppi_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_item      (in_item),
    .vertex_count (vertex_count),
    .cmd          (cmd),
    .status       (status)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while an item is in flight");

  a_pipe_empty_on_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !status.busy)
    else $error("edge pipeline busy when a new item is loaded");

  a_move_order: assert property (@(posedge clk) disable iff (rst)
    cmd.move_wr |-> $past(cmd.move_rd))
    else $error("move write without a preceding vertex read");
`endif

endmodule
